@@ hdl/efra_pkg.sv @@
package efra_pkg;

  localparam int ROOMS      = 16;
  localparam int COUNT_BITS = 20;
  localparam int ROOM_W     = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int TIME_W     = 48;
  localparam int IN_TIME_W  = 32;
  localparam int CFG_W      = 5;

  localparam logic [TIME_W-1:0]     TIME_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [IN_TIME_W-1:0] start_time;
    logic [IN_TIME_W-1:0] end_time;
    logic                 first_of_set;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        room_index;
    logic [TIME_W-1:0] actual_start;
    logic [TIME_W-1:0] actual_end;
    logic              delayed;
    logic [3:0]        busiest_room;
    logic              overflow;
  } out_item_t;

  // Program steps of the sequencer.
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_SCAN = 3'd1,
    S_CALC = 3'd2,
    S_UPD  = 3'd3,
    S_EMIT = 3'd4
  } step_e;

  // Jump conditions: the sequencer stays on the current step until the
  // condition allows the jump to the target step.
  typedef enum logic [1:0] {
    C_ALWAYS   = 2'd0,
    C_IN_ITEM  = 2'd1,
    C_SCAN_END = 2'd2,
    C_OUT_FREE = 2'd3
  } cond_e;

  typedef struct packed {
    cond_e cond;
    step_e target;
    logic  ld_item;
    logic  scan;
    logic  calc;
    logic  upd;
    logic  emit;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic scan_more;
    logic out_free;
  } stat_t;

  // Control store.
  function automatic ctl_t ucode(step_e pc);
    ctl_t cw;
    cw = '{cond: C_ALWAYS, target: S_IDLE, default: 1'b0};
    unique case (pc)
      S_IDLE: begin
        cw.cond    = C_IN_ITEM;
        cw.target  = S_SCAN;
        cw.ld_item = 1'b1;
      end
      S_SCAN: begin
        cw.cond   = C_SCAN_END;
        cw.target = S_CALC;
        cw.scan   = 1'b1;
      end
      S_CALC: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_UPD;
        cw.calc   = 1'b1;
      end
      S_UPD: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_EMIT;
        cw.upd    = 1'b1;
      end
      S_EMIT: begin
        cw.cond   = C_OUT_FREE;
        cw.target = S_IDLE;
        cw.emit   = 1'b1;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ hdl/earliest_free_room_allocator.sv @@
// Books each request into the lowest-numbered free room, or into the room
// that frees first, and reports the busiest room so far. An item goes
// through these steps in order: the block takes it, then the scan walks
// the state of each room in use through its single read port, then the
// block computes the times, writes the chosen room back and loads the
// result register. A room count of zero scans one room and a count above
// sixteen scans sixteen. The load waits while an earlier result is still
// stalled downstream, which adds that wait to the item. The next item is
// taken as soon as the result is loaded, even while that result still
// waits downstream. Writes to room_count are taken at any time and are
// meant only while the block is idle.
module earliest_free_room_allocator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  efra_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output efra_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [efra_pkg::CFG_W-1:0]           cfg_data_i
);
  import efra_pkg::*;

  logic [CFG_W-1:0]  room_count_q;
  logic [ROOM_W-1:0] last_room;
  ctl_t              ctl;
  stat_t             stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= CFG_W'(ROOMS);
    end else if (cfg_valid_i) begin
      room_count_q <= cfg_data_i;
    end
  end

  // Zero rooms acts as one, and counts beyond the built rooms are clipped.
  always_comb begin
    if (room_count_q == '0) begin
      last_room = '0;
    end else if (int'(room_count_q) > ROOMS) begin
      last_room = ROOM_W'(ROOMS - 1);
    end else begin
      last_room = ROOM_W'(room_count_q - CFG_W'(1));
    end
  end

  efra_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  efra_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .last_room_i (last_room),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/efra_seq.sv @@
module efra_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  efra_pkg::stat_t stat_i,
  output efra_pkg::ctl_t  ctl_o
);
  import efra_pkg::*;

  step_e pc_q, pc_d;
  ctl_t  cw;
  logic  go;

  assign cw    = ucode(pc_q);
  assign ctl_o = cw;

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:   go = 1'b1;
      C_IN_ITEM:  go = stat_i.in_fire;
      C_SCAN_END: go = !stat_i.scan_more;
      C_OUT_FREE: go = stat_i.out_free;
      default:    go = 1'b1;
    endcase
    pc_d = go ? cw.target : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ hdl/efra_dp.sv @@
module efra_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  efra_pkg::ctl_t                ctl_i,
  output efra_pkg::stat_t               stat_o,
  input  logic [efra_pkg::ROOM_W-1:0]   last_room_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  efra_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output efra_pkg::out_item_t           out_data_o
);
  import efra_pkg::*;

  // Room state. An entry whose valid bit is clear reads as zero.
  logic [TIME_W-1:0]     ft_q  [ROOMS];
  logic [COUNT_BITS-1:0] cnt_q [ROOMS];
  logic [ROOMS-1:0]      vld_q;

  logic [IN_TIME_W-1:0]  start_q;
  logic [IN_TIME_W-1:0]  dur_q;
  logic [ROOM_W-1:0]     idx_q;
  logic                  found_q;
  logic [ROOM_W-1:0]     room_q;
  logic [ROOM_W-1:0]     earl_q;
  logic [TIME_W-1:0]     etime_q;
  logic [ROOM_W-1:0]     best_q;
  logic [COUNT_BITS-1:0] bcnt_q;
  logic [ROOM_W-1:0]     sel_q;
  logic [TIME_W-1:0]     act_start_q;
  logic [TIME_W-1:0]     act_end_q;
  logic                  delayed_q;
  logic                  ovf_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic                  in_fire;
  logic                  out_free;
  logic [ROOM_W-1:0]     rd_addr;
  logic [TIME_W-1:0]     rd_ft;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [TIME_W-1:0]     calc_start;
  logic [TIME_W:0]       calc_sum;
  logic                  cnt_sat;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [ROOM_W-1:0]     new_best;

  assign in_stall_o  = !ctl_i.ld_item;
  assign in_fire     = in_valid_i && ctl_i.ld_item;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o = '{in_fire: in_fire, scan_more: (idx_q != last_room_i), out_free: out_free};

  // One read port: the scan index, or the chosen room during write-back.
  assign rd_addr = ctl_i.upd ? sel_q : idx_q;
  assign rd_ft   = vld_q[rd_addr] ? ft_q[rd_addr] : '0;
  assign rd_cnt  = vld_q[rd_addr] ? cnt_q[rd_addr] : '0;

  assign calc_start = found_q ? TIME_W'(start_q) : etime_q;
  assign calc_sum   = {1'b0, calc_start} + (TIME_W + 1)'(dur_q);

  assign cnt_sat = (rd_cnt == COUNT_MAX);
  assign new_cnt = cnt_sat ? COUNT_MAX : rd_cnt + COUNT_BITS'(1);

  // Only the chosen room's count grows, so the busiest room is either the
  // one found during the scan or the chosen room.
  always_comb begin
    new_best = best_q;
    if (sel_q != best_q) begin
      if (new_cnt > bcnt_q || (new_cnt == bcnt_q && sel_q < best_q)) begin
        new_best = sel_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (in_fire && in_data_i.first_of_set) begin
      vld_q <= '0;
    end else if (ctl_i.upd) begin
      vld_q[sel_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      ft_q[sel_q]  <= act_end_q;
      cnt_q[sel_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= in_data_i.start_time;
      dur_q   <= (in_data_i.end_time > in_data_i.start_time)
                 ? in_data_i.end_time - in_data_i.start_time : '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end
    if (ctl_i.scan) begin
      if (!found_q && rd_ft <= TIME_W'(start_q)) begin
        room_q  <= idx_q;
        found_q <= 1'b1;
      end
      if (idx_q == '0 || rd_ft < etime_q) begin
        earl_q  <= idx_q;
        etime_q <= rd_ft;
      end
      if (idx_q == '0 || rd_cnt > bcnt_q) begin
        best_q <= idx_q;
        bcnt_q <= rd_cnt;
      end
      idx_q <= idx_q + ROOM_W'(1);
    end
    if (ctl_i.calc) begin
      sel_q       <= found_q ? room_q : earl_q;
      act_start_q <= calc_start;
      act_end_q   <= calc_sum[TIME_W] ? TIME_MAX : calc_sum[TIME_W-1:0];
      ovf_q       <= calc_sum[TIME_W];
      delayed_q   <= !found_q;
    end
    if (ctl_i.upd) begin
      best_q <= new_best;
      ovf_q  <= ovf_q | cnt_sat;
    end
    if (ctl_i.emit && out_free) begin
      out_q.room_index   <= 4'(sel_q);
      out_q.actual_start <= act_start_q;
      out_q.actual_end   <= act_end_q;
      out_q.delayed      <= delayed_q;
      out_q.busiest_room <= 4'(best_q);
      out_q.overflow     <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ hdl/efra_chk.sv @@
module efra_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input efra_pkg::out_item_t out_data_o
);

  // A held result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // After an item is taken the block is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item in work");

  // A booking never ends before it starts.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.actual_end >= out_data_o.actual_start)
    else $error("actual end before actual start");

  // A result that was not delayed starts at a requested start time.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.delayed |-> out_data_o.actual_start[47:32] == '0)
    else $error("undelayed start outside request range");

endmodule

bind earliest_free_room_allocator efra_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
